FILE: rtl/core/sorted_priority_queue_top_defines.svh
// Assertion macros shared by the sorted priority queue checkers.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/spq_pkg.sv
// Shared types and codes of the sorted priority queue.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package spq_pkg;

    localparam int unsigned OP_BITS     = 2;
    localparam int unsigned STATUS_BITS = 3;
    localparam int unsigned FIELD_BITS  = 16;
    localparam int unsigned COUNT_BITS  = 5;

    typedef enum logic [OP_BITS-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_CHG = 2'd2,
        OP_CLR = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_RAISED    = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_INSERT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_REM
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// One slot of the sorted queue: holds a tag and a priority and trades them
// with its neighbors on insert and remove. Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; #(
    parameter int unsigned TW = 16
) (
    input  wire logic                         i_clk,
    input  wire t_cell_ctl                    i_ctl,
    input  wire logic                         i_valid,
    input  wire logic [TW-1:0]                i_key_tag,
    input  wire logic signed [FIELD_BITS-1:0] i_key_pri,
    input  wire logic                         i_left_stay,
    input  wire logic [TW-1:0]                i_left_tag,
    input  wire logic signed [FIELD_BITS-1:0] i_left_pri,
    input  wire logic [TW-1:0]                i_right_tag,
    input  wire logic signed [FIELD_BITS-1:0] i_right_pri,
    output logic      [TW-1:0]                o_tag,
    output logic signed [FIELD_BITS-1:0]      o_pri,
    output logic                              o_stay,
    output logic                              o_hit
);

    logic [TW-1:0]                r_tag, n_tag;
    logic signed [FIELD_BITS-1:0] r_pri, n_pri;

    // An entry stays put on insert when the new key sorts after it.
    assign o_stay = i_valid &&
                    ((r_pri < i_key_pri) || ((r_pri == i_key_pri) && (r_tag <= i_key_tag)));
    assign o_hit  = i_valid && (r_tag == i_key_tag);
    assign o_tag  = r_tag;
    assign o_pri  = r_pri;

    always_comb begin
        n_tag = r_tag;
        n_pri = r_pri;
        case (i_ctl.op)
            CELL_INS: begin
                if (!o_stay) begin
                    if (i_left_stay) begin
                        n_tag = i_key_tag;
                        n_pri = i_key_pri;
                    end else begin
                        n_tag = i_left_tag;
                        n_pri = i_left_pri;
                    end
                end
            end
            CELL_REM: begin
                if (i_ctl.shift) begin
                    n_tag = i_right_tag;
                    n_pri = i_right_pri;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_pri <= n_pri;
    end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: a row of spq_cell slots and the
// sequencer that drives them. Depends on spq_pkg and spq_cell.
//
// Usage: an operation beat is taken at a rising edge where start is high and
// busy is low. Operations are enqueue, dequeue of the head, change of
// priority and clear. Exactly one result beat follows each operation; it is
// on the o_ ports for one cycle, marked by o_valid, and cannot be held off.
// Head tag, head priority and entry count in the result describe the queue
// after the operation.
// Enqueue, dequeue and clear finish at the accept edge: the result appears in
// the next cycle and busy stays low, so one of these may be taken every cycle.
// Change of priority runs as a search of all slots at the accept edge, a
// compare and removal of the found slot in S_CHECK, then a reinsert in
// S_INSERT; busy is high during the compare and the reinsert, and the result
// follows the reinsert. When the tag is missing or the priority would rise,
// the result follows the compare instead, with busy high only for the compare.
// All slots compare against the key in parallel and shift by one place at once;
// the first-match search is a log-depth prefix over the slots.
// Reset empties the queue, drops busy and any pending result.
`default_nettype none

module sorted_priority_queue_top import spq_pkg::*; #(
    parameter int unsigned DEPTH    = 16,
    parameter int unsigned TAG_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [OP_BITS-1:0]           i_operation,
    input  wire logic [FIELD_BITS-1:0]        i_tag,
    input  wire logic signed [FIELD_BITS-1:0] i_priority_req,
    output logic                              o_valid,
    output logic [STATUS_BITS-1:0]            o_status,
    output logic [FIELD_BITS-1:0]             o_removed_tag,
    output logic signed [FIELD_BITS-1:0]      o_removed_priority,
    output logic [FIELD_BITS-1:0]             o_head_tag,
    output logic signed [FIELD_BITS-1:0]      o_head_priority,
    output logic [COUNT_BITS-1:0]             o_entry_count,
    output logic                              o_is_empty
);

    localparam int unsigned TW     = (TAG_BITS < FIELD_BITS) ? TAG_BITS : FIELD_BITS;
    localparam int unsigned CW     = $clog2(DEPTH + 1);
    localparam int unsigned LEVELS = $clog2(DEPTH);

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic                         r_valid, n_valid;
    t_status                      r_status, n_status;
    logic [TW-1:0]                r_rtag, n_rtag;
    logic signed [FIELD_BITS-1:0] r_rpri, n_rpri;
    logic [TW-1:0]                r_tag;
    logic signed [FIELD_BITS-1:0] r_pri;
    logic [DEPTH-1:0]             r_after;

    logic [TW-1:0]                w_tag   [DEPTH];
    logic signed [FIELD_BITS-1:0] w_pri   [DEPTH];
    logic [DEPTH-1:0]             w_stay;
    logic [DEPTH-1:0]             w_hit;
    logic [DEPTH-1:0]             w_pre   [LEVELS+1];
    logic [DEPTH-1:0]             w_first;
    logic [TW-1:0]                key_tag;
    logic signed [FIELD_BITS-1:0] key_pri;
    logic signed [FIELD_BITS-1:0] sel_pri;
    t_cell_op                     cell_op;
    logic                         shift_all;
    logic                         accept;
    t_op                          op_in;

    assign accept  = start && (r_state == S_IDLE);
    assign op_in   = t_op'(i_operation);
    assign key_tag = (r_state == S_IDLE) ? i_tag[TW-1:0] : r_tag;
    assign key_pri = (r_state == S_IDLE) ? i_priority_req : r_pri;

    // Prefix OR of the match flags: bit i is set when some slot at or below i
    // holds the searched tag.
    assign w_pre[0] = w_hit;
    for (genvar l = 0; l < LEVELS; l++) begin : g_pre
        for (genvar i = 0; i < DEPTH; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_or
                assign w_pre[l+1][i] = w_pre[l][i] | w_pre[l][i-(1<<l)];
            end else begin : g_pass
                assign w_pre[l+1][i] = w_pre[l][i];
            end
        end
    end

    assign w_first = r_after & ~(r_after << 1);

    always_comb begin
        sel_pri = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_pri = sel_pri | (w_first[i] ? w_pri[i] : '0);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_cell_ctl                    ctl;
        logic                         left_stay;
        logic [TW-1:0]                left_tag, right_tag;
        logic signed [FIELD_BITS-1:0] left_pri, right_pri;

        assign ctl.op    = cell_op;
        assign ctl.shift = shift_all | r_after[i];

        if (i == 0) begin : g_first
            assign left_stay = 1'b1;
            assign left_tag  = '0;
            assign left_pri  = '0;
        end else begin : g_mid
            assign left_stay = w_stay[i-1];
            assign left_tag  = w_tag[i-1];
            assign left_pri  = w_pri[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_tag = '0;
            assign right_pri = '0;
        end else begin : g_inner
            assign right_tag = w_tag[i+1];
            assign right_pri = w_pri[i+1];
        end

        spq_cell #(
            .TW (TW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_valid     (CW'(i) < r_count),
            .i_key_tag   (key_tag),
            .i_key_pri   (key_pri),
            .i_left_stay (left_stay),
            .i_left_tag  (left_tag),
            .i_left_pri  (left_pri),
            .i_right_tag (right_tag),
            .i_right_pri (right_pri),
            .o_tag       (w_tag[i]),
            .o_pri       (w_pri[i]),
            .o_stay      (w_stay[i]),
            .o_hit       (w_hit[i])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_rtag    = r_rtag;
        n_rpri    = r_rpri;
        cell_op   = CELL_HOLD;
        shift_all = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_rtag   = '0;
                    n_rpri   = '0;
                    case (op_in)
                        OP_ENQ: begin
                            n_valid = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                cell_op = CELL_INS;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_DEQ: begin
                            n_valid = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                cell_op   = CELL_REM;
                                shift_all = 1'b1;
                                n_rtag    = w_tag[0];
                                n_rpri    = w_pri[0];
                                n_count   = r_count - 1'b1;
                            end
                        end
                        OP_CHG: begin
                            n_state = S_CHECK;
                        end
                        OP_CLR: begin
                            n_valid = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (!r_after[DEPTH-1]) begin
                    n_status = ST_NOT_FOUND;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (sel_pri < r_pri) begin
                    n_status = ST_RAISED;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    cell_op = CELL_REM;
                    n_count = r_count - 1'b1;
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                cell_op = CELL_INS;
                n_count = r_count + 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rtag   <= n_rtag;
        r_rpri   <= n_rpri;
        if (accept) begin
            r_tag   <= i_tag[TW-1:0];
            r_pri   <= i_priority_req;
            r_after <= w_pre[LEVELS];
        end
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_removed_tag      = FIELD_BITS'(r_rtag);
    assign o_removed_priority = r_rpri;
    assign o_head_tag         = (r_count != '0) ? FIELD_BITS'(w_tag[0]) : '0;
    assign o_head_priority    = (r_count != '0) ? w_pri[0] : '0;
    assign o_entry_count      = COUNT_BITS'(r_count);
    assign o_is_empty         = (r_count == '0);

endmodule

`default_nettype wire

FILE: rtl/core/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top_defines.svh.
`default_nettype none

`include "sorted_priority_queue_top_defines.svh"

module spq_checker import spq_pkg::*; (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic [OP_BITS-1:0]           i_operation,
    input wire logic                         o_valid,
    input wire logic [STATUS_BITS-1:0]       o_status,
    input wire logic [FIELD_BITS-1:0]        o_removed_tag,
    input wire logic signed [FIELD_BITS-1:0] o_removed_priority,
    input wire logic [FIELD_BITS-1:0]        o_head_tag,
    input wire logic signed [FIELD_BITS-1:0] o_head_priority,
    input wire logic [COUNT_BITS-1:0]        o_entry_count,
    input wire logic                         o_is_empty
);

    logic chk_fast_op;

    // Every operation but a change of priority reports in the very next cycle.
    assign chk_fast_op = start && !busy && (i_operation != OP_CHG);

    `SPQ_ASSERT_NXT(a_fast_result, chk_fast_op, o_valid && !busy, "fast op gave no result beat")
    `SPQ_ASSERT_IMP(a_empty_head, o_valid && o_is_empty, (o_head_tag == '0) && (o_head_priority == '0) && (o_entry_count == '0), "empty queue shows a head")
    `SPQ_ASSERT_IMP(a_fail_no_removal, o_valid && (o_status != ST_OK), (o_removed_tag == '0) && (o_removed_priority == '0), "failed op reports a removal")
    `SPQ_ASSERT_IMP(a_empty_status, o_valid && (o_status == ST_EMPTY), o_is_empty, "empty status with entries held")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

`default_nettype wire

FILE: tb/sorted_priority_queue_top_tb.sv
// Self-checking testbench for sorted_priority_queue_top: directed and random
// operation beats, checked against an in-bench model of the sorted queue.
// Depends on spq_pkg and the sorted_priority_queue_top RTL.
`default_nettype none

module sorted_priority_queue_top_tb;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned RANDOM_OPS = 950;
    localparam int unsigned TAIL_LIMIT = 200;

    typedef struct {
        t_op                     op;
        logic [FIELD_BITS-1:0]   tag;
        logic signed [15:0]      pri;
        bit                      wait_for_idle;
    } t_spq_request;

    typedef struct {
        t_status                 status;
        logic [FIELD_BITS-1:0]   removed_tag;
        logic signed [15:0]      removed_pri;
        logic [FIELD_BITS-1:0]   head_tag;
        logic signed [15:0]      head_pri;
        logic [COUNT_BITS-1:0]   count;
        logic                    is_empty;
    } t_spq_outcome;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [OP_BITS-1:0]           i_operation = '0;
    logic [FIELD_BITS-1:0]        i_tag = '0;
    logic signed [FIELD_BITS-1:0] i_priority_req = '0;
    logic                         o_valid;
    logic [STATUS_BITS-1:0]       o_status;
    logic [FIELD_BITS-1:0]        o_removed_tag;
    logic signed [FIELD_BITS-1:0] o_removed_priority;
    logic [FIELD_BITS-1:0]        o_head_tag;
    logic signed [FIELD_BITS-1:0] o_head_priority;
    logic [COUNT_BITS-1:0]        o_entry_count;
    logic                         o_is_empty;

    sorted_priority_queue_top #(
        .DEPTH   (DEPTH),
        .TAG_BITS(16)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_tag             (i_tag),
        .i_priority_req    (i_priority_req),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_removed_tag     (o_removed_tag),
        .o_removed_priority(o_removed_priority),
        .o_head_tag        (o_head_tag),
        .o_head_priority   (o_head_priority),
        .o_entry_count     (o_entry_count),
        .o_is_empty        (o_is_empty)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the queue contents, kept sorted like the block's slots.
    logic [FIELD_BITS-1:0] shadow_tag [DEPTH];
    logic signed [15:0]    shadow_pri [DEPTH];
    int                    shadow_count = 0;

    t_spq_request op_backlog[$];
    t_spq_outcome queue_outcomes[$];

    logic [FIELD_BITS-1:0] tag_pool [8];

    bit beat_taken = 1'b0;
    int beats_sent = 0;
    int beats_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int op_hist [4] = '{default: 0};
    int status_hist [5] = '{default: 0};

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] result %0d: %s is %0h, expected %0h", $realtime, results_seen,
                 field, got, want);
        mismatches++;
    endtask

    function automatic void shadow_insert(logic [FIELD_BITS-1:0] tag, logic signed [15:0] pri);
        int pos;
        int k;
        pos = 0;
        // New entries land after everything equal in both priority and tag.
        while (pos < shadow_count && !(shadow_pri[pos] > pri ||
               (shadow_pri[pos] == pri && shadow_tag[pos] > tag)))
            pos++;
        for (k = shadow_count; k > pos; k--) begin
            shadow_tag[k] = shadow_tag[k-1];
            shadow_pri[k] = shadow_pri[k-1];
        end
        shadow_tag[pos] = tag;
        shadow_pri[pos] = pri;
        shadow_count++;
    endfunction

    function automatic void shadow_remove(int pos);
        int k;
        for (k = pos; k + 1 < shadow_count; k++) begin
            shadow_tag[k] = shadow_tag[k+1];
            shadow_pri[k] = shadow_pri[k+1];
        end
        shadow_count--;
    endfunction

    function automatic t_spq_outcome apply_queue_op(t_op op, logic [FIELD_BITS-1:0] tag,
                                                    logic signed [15:0] pri);
        t_spq_outcome res;
        int hit;
        int k;
        res.status      = ST_OK;
        res.removed_tag = '0;
        res.removed_pri = '0;
        case (op)
            OP_ENQ: begin
                if (shadow_count >= DEPTH)
                    res.status = ST_FULL;
                else
                    shadow_insert(tag, pri);
            end
            OP_DEQ: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.removed_tag = shadow_tag[0];
                    res.removed_pri = shadow_pri[0];
                    shadow_remove(0);
                end
            end
            OP_CHG: begin
                hit = -1;
                for (k = 0; k < shadow_count && hit < 0; k++)
                    if (shadow_tag[k] == tag)
                        hit = k;
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else if (shadow_pri[hit] < pri) begin
                    res.status = ST_RAISED;
                end else begin
                    shadow_remove(hit);
                    shadow_insert(tag, pri);
                end
            end
            default: shadow_count = 0;
        endcase
        res.head_tag = (shadow_count > 0) ? shadow_tag[0] : '0;
        res.head_pri = (shadow_count > 0) ? shadow_pri[0] : '0;
        res.count    = shadow_count[COUNT_BITS-1:0];
        res.is_empty = (shadow_count == 0);
        return res;
    endfunction

    function automatic void add_request(t_op op, logic [FIELD_BITS-1:0] tag,
                                        logic signed [15:0] pri, bit hold);
        t_spq_request req;
        req.op            = op;
        req.tag           = tag;
        req.pri           = pri;
        req.wait_for_idle = hold;
        op_backlog.push_back(req);
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_tag();
        if ($urandom_range(0, 99) < 80)
            return tag_pool[$urandom_range(0, 7)];
        return FIELD_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic logic signed [15:0] pick_priority();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 16'sh8000;
        if (roll < 16)
            return 16'sh7fff;
        if (roll < 50)
            return 16'(signed'($urandom_range(0, 8)) - 4);
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mix is given in percent for enqueue, dequeue and change; the rest is clear.
    function automatic void add_random_episode(int len, int enq_pct, int deq_pct,
                                               int chg_pct, bit hold_first);
        int n;
        int roll;
        t_op op;
        for (n = 0; n < len; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < enq_pct)
                op = OP_ENQ;
            else if (roll < enq_pct + deq_pct)
                op = OP_DEQ;
            else if (roll < enq_pct + deq_pct + chg_pct)
                op = OP_CHG;
            else
                op = OP_CLR;
            add_request(op, pick_tag(), pick_priority(), hold_first && n == 0);
        end
    endfunction

    // Driver: a new beat goes out once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || beat_taken)) begin
            if (op_backlog.size() == 0) begin
                start <= 1'b0;
            end else if (op_backlog[0].wait_for_idle && queue_outcomes.size() != 0) begin
                start <= 1'b0;
            end else if ((beats_sent < 400 || beats_sent > 600) &&
                         $urandom_range(0, 99) < 28) begin
                start <= 1'b0;
            end else begin
                i_operation    <= op_backlog[0].op;
                i_tag          <= op_backlog[0].tag;
                i_priority_req <= op_backlog[0].pri;
                start          <= 1'b1;
                op_backlog.pop_front();
                beats_sent++;
            end
        end
    end

    // Monitor: check any result against the oldest expectation, then predict
    // the beat taken at this edge.
    always @(posedge i_clk) begin
        t_spq_outcome want;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= start && !busy;
            if (o_valid === 1'b1) begin
                results_seen++;
                if (queue_outcomes.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = queue_outcomes.pop_front();
                    if (want.status <= ST_FULL)
                        status_hist[want.status]++;
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_removed_tag !== want.removed_tag)
                        report_mismatch("removed_tag", o_removed_tag, want.removed_tag);
                    if (o_removed_priority !== want.removed_pri)
                        report_mismatch("removed_priority", o_removed_priority,
                                        want.removed_pri);
                    if (o_head_tag !== want.head_tag)
                        report_mismatch("head_tag", o_head_tag, want.head_tag);
                    if (o_head_priority !== want.head_pri)
                        report_mismatch("head_priority", o_head_priority, want.head_pri);
                    if (o_entry_count !== want.count)
                        report_mismatch("entry_count", o_entry_count, want.count);
                    if (o_is_empty !== want.is_empty)
                        report_mismatch("is_empty", o_is_empty, want.is_empty);
                end
            end
            if (start && !busy) begin
                queue_outcomes.push_back(apply_queue_op(t_op'(i_operation), i_tag,
                                                        i_priority_req));
                op_hist[i_operation]++;
                beats_accepted++;
            end
        end
    end

    initial begin
        #200000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int total_beats;
        int random_added;
        int kind;
        int w;
        int k;
        bit hold_next;

        // Directed: empty-queue errors, extremes, ties, duplicates and every
        // outcome of a priority change.
        add_request(OP_DEQ, 16'h0000, 16'sh0000, 1'b0);
        add_request(OP_CHG, 16'h1234, 16'sh0000, 1'b0);
        add_request(OP_ENQ, 16'hffff, 16'sh7fff, 1'b0);
        add_request(OP_ENQ, 16'h0000, 16'sh8000, 1'b0);
        add_request(OP_ENQ, 16'h0005, 16'sd100, 1'b0);
        add_request(OP_ENQ, 16'h0005, 16'sd100, 1'b0);
        add_request(OP_ENQ, 16'h0003, 16'sd100, 1'b0);
        add_request(OP_ENQ, 16'h0007, -16'sd1, 1'b0);
        add_request(OP_CHG, 16'h0005, 16'sd200, 1'b0);
        add_request(OP_CHG, 16'h0005, 16'sd100, 1'b0);
        add_request(OP_CHG, 16'h0007, 16'sh8000, 1'b0);
        add_request(OP_CHG, 16'hffff, 16'sh8000, 1'b0);
        add_request(OP_CHG, 16'h0009, 16'sd0, 1'b0);
        add_request(OP_DEQ, 16'h0000, 16'sh0000, 1'b0);
        add_request(OP_DEQ, 16'h0000, 16'sh0000, 1'b0);
        add_request(OP_CLR, 16'h0000, 16'sh0000, 1'b0);
        add_request(OP_DEQ, 16'h0000, 16'sh0000, 1'b0);
        add_request(OP_CLR, 16'h0000, 16'sh0000, 1'b0);

        // Random episodes, each with its own tag pool so that changes find
        // their targets; fill bursts push the queue into the full state.
        random_added = 0;
        hold_next = 1'b1;
        while (random_added < RANDOM_OPS) begin
            for (k = 0; k < 8; k++)
                tag_pool[k] = (k < 4) ? FIELD_BITS'($urandom_range(0, 15))
                                      : FIELD_BITS'($urandom_range(0, 65535));
            kind = $urandom_range(0, 3);
            case (kind)
                0: add_random_episode(20, 100, 0, 0, hold_next);
                1: add_random_episode(30, 60, 15, 22, hold_next);
                2: add_random_episode(30, 15, 55, 27, hold_next);
                default: add_random_episode(30, 30, 20, 47, hold_next);
            endcase
            hold_next = 1'b0;
            if (random_added < RANDOM_OPS / 2 && random_added + 30 >= RANDOM_OPS / 2)
                hold_next = 1'b1;
            random_added += (kind == 0) ? 20 : 30;
        end
        total_beats = op_backlog.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_accepted < total_beats)
            @(posedge i_clk);
        for (w = 0; w < TAIL_LIMIT && queue_outcomes.size() != 0; w++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (queue_outcomes.size() != 0)
            report_mismatch("results still outstanding", queue_outcomes.size(), 0);

        $display("Ran %0d beats: %0d enqueue, %0d dequeue, %0d change, %0d clear.",
                 beats_accepted, op_hist[OP_ENQ], op_hist[OP_DEQ], op_hist[OP_CHG],
                 op_hist[OP_CLR]);
        $display("Outcomes: %0d ok, %0d empty, %0d not found, %0d raised, %0d full.",
                 status_hist[ST_OK], status_hist[ST_EMPTY], status_hist[ST_NOT_FOUND],
                 status_hist[ST_RAISED], status_hist[ST_FULL]);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
